[hdl/htw_pkg.sv]
// Package for the hashed timing wheel: sizes, action codes and the command
// record passed from the front end through the queue to the scan engine.
// No dependencies.
package htw_pkg;

  // Sizes of the wheel.
  localparam int NUM_TIMERS    = 16;
  localparam int BUCKETS       = 256;
  localparam int RESOLUTION_MS = 16;
  localparam int QUEUE_DEPTH   = 2;

  // Field widths.
  localparam int ACTION_W = 2;
  localparam int SLOT_W   = 4;
  localparam int TIME_W   = 32;
  localparam int TAG_W    = 32;
  localparam int REV_W    = 24;
  localparam int BUCKET_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int IDX_W    = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int PTR_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);

  // Action codes on the input channel, also used as command codes.
  localparam logic [ACTION_W-1:0] ACT_SCHEDULE = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_CANCEL   = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_TICK     = 2'd2;

  // One command for the scan engine. For a tick, bucket holds the new
  // wheel position.
  typedef struct packed {
    logic [ACTION_W-1:0] op;
    logic [IDX_W-1:0]    slot;
    logic [BUCKET_W-1:0] bucket;
    logic [REV_W-1:0]    revs;
    logic [TAG_W-1:0]    tag;
  } cmd_t;

endpackage

[hdl/htw_ifs.sv]
// Channel interfaces of the hashed timing wheel: the request channel and the
// expiry channel, each a valid/ready beat. Depends on htw_pkg.
interface htw_in_if;
  logic                         valid;
  logic                         ready;
  logic [htw_pkg::ACTION_W-1:0] action;
  logic [htw_pkg::SLOT_W-1:0]   slot;
  logic [htw_pkg::TIME_W-1:0]   now_ms;
  logic [htw_pkg::TIME_W-1:0]   duration_ms;
  logic [htw_pkg::TAG_W-1:0]    timer_tag;

  modport source (output valid, action, slot, now_ms, duration_ms, timer_tag,
                  input ready);
  modport sink (input valid, action, slot, now_ms, duration_ms, timer_tag,
                output ready);
endinterface

interface htw_out_if;
  logic                       valid;
  logic                       ready;
  logic [htw_pkg::TAG_W-1:0]  expired_tag;
  logic [htw_pkg::SLOT_W-1:0] expired_slot;
  logic                       last;

  modport source (output valid, expired_tag, expired_slot, last, input ready);
  modport sink (input valid, expired_tag, expired_slot, last, output ready);
endinterface

[hdl/htw_fifo.sv]
// Two-entry command queue between the front end and the scan engine.
// Depends on htw_pkg.
module htw_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  htw_pkg::cmd_t push_data,
  output logic          full,
  input  logic          pop,
  output htw_pkg::cmd_t pop_data,
  output logic          empty
);
  import htw_pkg::*;

  cmd_t             mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full     = (count_r == CNT_W'(QUEUE_DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[hdl/htw_front.sv]
// Front end of the hashed timing wheel: takes request beats, keeps the wheel
// position and tick time, and turns each request into a queue command.
// Depends on htw_pkg and htw_ifs.
module htw_front (
  input  logic          clk,
  input  logic          rst_n,
  htw_in_if.sink        in_bus,
  output logic          push,
  output htw_pkg::cmd_t push_data,
  input  logic          q_full
);
  import htw_pkg::*;

  localparam logic [TIME_W-1:0] REV_MAX = TIME_W'((1 << REV_W) - 1);

  logic [BUCKET_W-1:0] wheel_pos_r, wheel_pos_nxt;
  logic [TIME_W-1:0]   last_tick_r, last_tick_nxt;

  logic                accept;
  logic                slot_ok;
  logic                cmd_ok;
  logic [TIME_W-1:0]   diff;
  logic [TIME_W-1:0]   ticks;
  logic [TIME_W-1:0]   revs_wide;
  logic [BUCKET_W-1:0] ticks_mod;
  logic [BUCKET_W:0]   bucket_sum;
  logic [BUCKET_W-1:0] bucket;
  logic [REV_W-1:0]    revs;

  assign in_bus.ready = !q_full;
  assign accept       = in_bus.valid && in_bus.ready;
  assign slot_ok      = (int'(in_bus.slot) < NUM_TIMERS);

  always_comb begin
    case (in_bus.action)
      ACT_SCHEDULE: cmd_ok = slot_ok;
      ACT_CANCEL:   cmd_ok = slot_ok;
      ACT_TICK:     cmd_ok = 1'b1;
      default:      cmd_ok = 1'b0;
    endcase
  end

  // Ticks from the last wheel step; a negative distance counts as none.
  assign diff      = in_bus.now_ms + in_bus.duration_ms - last_tick_r;
  assign ticks     = diff[TIME_W-1] ? '0 : diff / RESOLUTION_MS;
  assign revs_wide = ticks / BUCKETS;
  assign revs      = (revs_wide > REV_MAX) ? REV_MAX[REV_W-1:0] : revs_wide[REV_W-1:0];
  assign ticks_mod = BUCKET_W'(ticks % BUCKETS);
  assign bucket_sum = {1'b0, wheel_pos_r} + {1'b0, ticks_mod};
  assign bucket    = (bucket_sum >= (BUCKET_W + 1)'(BUCKETS))
                   ? BUCKET_W'(bucket_sum - (BUCKET_W + 1)'(BUCKETS))
                   : bucket_sum[BUCKET_W-1:0];

  assign wheel_pos_nxt = (wheel_pos_r == BUCKET_W'(BUCKETS - 1)) ? '0
                       : wheel_pos_r + 1'b1;
  assign last_tick_nxt = last_tick_r + TIME_W'(RESOLUTION_MS);

  assign push           = accept && cmd_ok;
  assign push_data.op   = in_bus.action;
  assign push_data.slot = IDX_W'(in_bus.slot);
  assign push_data.bucket = (in_bus.action == ACT_TICK) ? wheel_pos_nxt : bucket;
  assign push_data.revs = revs;
  assign push_data.tag  = in_bus.timer_tag;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wheel_pos_r <= '0;
      last_tick_r <= '0;
    end else if (accept && (in_bus.action == ACT_TICK)) begin
      wheel_pos_r <= wheel_pos_nxt;
      last_tick_r <= last_tick_nxt;
    end
  end

endmodule

[hdl/htw_back.sv]
// Scan engine of the hashed timing wheel: holds the timer slots, applies
// schedule and cancel commands and walks the slots on each tick.
// Depends on htw_pkg and htw_ifs.
module htw_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_empty,
  input  htw_pkg::cmd_t q_data,
  output logic          pop,
  htw_out_if.source     out_bus
);
  import htw_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  // Slot store.
  logic [NUM_TIMERS-1:0] active_r;
  logic [BUCKET_W-1:0]   bucket_r [NUM_TIMERS];
  logic [REV_W-1:0]      revs_r   [NUM_TIMERS];
  logic [TAG_W-1:0]      tag_r    [NUM_TIMERS];

  logic [1:0]          state_r, state_nxt;
  logic [IDX_W-1:0]    scan_idx_r, scan_idx_nxt;
  logic [BUCKET_W-1:0] pos_r;
  logic                hold_valid_r, hold_valid_nxt;
  logic [TAG_W-1:0]    hold_tag_r;
  logic [IDX_W-1:0]    hold_idx_r;
  logic                out_valid_r, out_valid_nxt;
  logic [TAG_W-1:0]    out_tag_r;
  logic [IDX_W-1:0]    out_idx_r;
  logic                out_last_r;

  logic out_free;
  logic hit;
  logic expire;
  logic scan_go;
  logic scan_end;
  logic load_out;
  logic load_last;
  logic load_hold;

  assign out_free = !out_valid_r || out_bus.ready;
  assign hit      = active_r[scan_idx_r] && (bucket_r[scan_idx_r] == pos_r);
  assign expire   = hit && (revs_r[scan_idx_r] == '0);
  assign scan_end = (scan_idx_r == IDX_W'(NUM_TIMERS - 1));
  assign pop      = (state_r == ST_IDLE) && !q_empty;

  always_comb begin
    state_nxt      = state_r;
    scan_idx_nxt   = scan_idx_r;
    hold_valid_nxt = hold_valid_r;
    scan_go        = 1'b0;
    load_out       = 1'b0;
    load_last      = 1'b0;
    load_hold      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (pop && (q_data.op == ACT_TICK)) begin
          state_nxt    = ST_SCAN;
          scan_idx_nxt = '0;
        end
      end
      ST_SCAN: begin
        // A second expiry pushes the held one out, so it waits for room.
        scan_go = !(expire && hold_valid_r && !out_free);
        if (scan_go) begin
          if (expire) begin
            load_out       = hold_valid_r;
            load_hold      = 1'b1;
            hold_valid_nxt = 1'b1;
          end
          if (scan_end) begin
            state_nxt    = ST_FLUSH;
            scan_idx_nxt = '0;
          end else begin
            scan_idx_nxt = scan_idx_r + 1'b1;
          end
        end
      end
      ST_FLUSH: begin
        if (!hold_valid_r) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          load_out       = 1'b1;
          load_last      = 1'b1;
          hold_valid_nxt = 1'b0;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_bus.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      scan_idx_r   <= '0;
      hold_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      scan_idx_r   <= scan_idx_nxt;
      hold_valid_r <= hold_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Active flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= '0;
    end else if (pop && (q_data.op == ACT_SCHEDULE)) begin
      active_r[q_data.slot] <= 1'b1;
    end else if (pop && (q_data.op == ACT_CANCEL)) begin
      active_r[q_data.slot] <= 1'b0;
    end else if (scan_go && expire) begin
      active_r[scan_idx_r] <= 1'b0;
    end
  end

  // Slot payload and scan payload registers.
  always_ff @(posedge clk) begin
    if (pop && (q_data.op == ACT_SCHEDULE)) begin
      bucket_r[q_data.slot] <= q_data.bucket;
      revs_r[q_data.slot]   <= q_data.revs;
      tag_r[q_data.slot]    <= q_data.tag;
    end else if (scan_go && hit && !expire) begin
      revs_r[scan_idx_r] <= revs_r[scan_idx_r] - 1'b1;
    end
    if (pop && (q_data.op == ACT_TICK)) begin
      pos_r <= q_data.bucket;
    end
    if (load_out) begin
      out_tag_r  <= hold_tag_r;
      out_idx_r  <= hold_idx_r;
      out_last_r <= load_last;
    end
    if (load_hold) begin
      hold_tag_r <= tag_r[scan_idx_r];
      hold_idx_r <= scan_idx_r;
    end
  end

  assign out_bus.valid        = out_valid_r;
  assign out_bus.expired_tag  = out_tag_r;
  assign out_bus.expired_slot = SLOT_W'(out_idx_r);
  assign out_bus.last         = out_last_r;

  // Nothing is held back between ticks.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !hold_valid_r)
    else $error("held expiry left over outside a tick scan");

  // An expiry that is not the last of its tick always has a successor held.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_last_r) |-> hold_valid_r)
    else $error("non-final expiry with no successor held");

  // The scan always starts from slot zero.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_SCAN) |-> (scan_idx_r == '0))
    else $error("scan index not parked at zero");

  // An expired slot is inactive afterwards.
  assert property (@(posedge clk) disable iff (!rst_n)
    (scan_go && expire) |=> !active_r[$past(scan_idx_r)])
    else $error("expired slot still active");

  // Commands are only taken between scans.
  assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (state_r == ST_IDLE) && !hold_valid_r)
    else $error("command taken during a scan");

endmodule

[hdl/hashed_timing_wheel.sv]
// Top level of the hashed timing wheel: front end, command queue and scan
// engine. Depends on htw_pkg, htw_ifs, htw_front, htw_fifo and htw_back.
//
// A hashed timing wheel over NUM_TIMERS timer slots and BUCKETS buckets, one
// bucket per RESOLUTION_MS step. Each request beat carries an action: a
// schedule (or reschedule) files a slot under a bucket with a remaining
// revolution count, a cancel clears the slot, and a tick advances the wheel
// one step and reports every timer in the new bucket that has no revolutions
// left, as one result beat each, in ascending slot order, with last set on
// the final beat of that tick. A tick with no expiries gives no beats. The
// front end takes a request beat in every cycle in which the two-entry
// command queue has room; it owns the wheel position and tick time, so the
// bucket and revolutions of a schedule are worked out on arrival. The scan
// engine applies a schedule or cancel as it takes the command. A tick takes
// the command, walks the slot store one slot per cycle while it is not
// stalled, and then releases the final expiry; it stalls only while the
// result register is still waiting on the consumer. A finished result sits
// in its own output register, with one more expiry held behind it, so the
// scan goes on while the consumer holds it off until a further expiry needs
// room. Timer slots need no clearing after reset: only their active flags are
// reset, and slot data is read only once a schedule has written it.
module hashed_timing_wheel (
  input  logic      clk,
  input  logic      rst_n,
  htw_in_if.sink    in_bus,
  htw_out_if.source out_bus
);
  import htw_pkg::*;

  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_empty;
  cmd_t q_push_data;
  cmd_t q_pop_data;

  htw_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_bus),
    .push      (q_push),
    .push_data (q_push_data),
    .q_full    (q_full)
  );

  htw_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .empty     (q_empty)
  );

  htw_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_data  (q_pop_data),
    .pop     (q_pop),
    .out_bus (out_bus)
  );

endmodule

[tb/htw_expiry_checker.sv]
// Expiry checker for the hashed timing wheel: watches both channels, keeps its
// own copy of the wheel, predicts every expiry beat and compares it.
// Depends on htw_pkg and htw_ifs.
module htw_expiry_checker (
  input  logic clk,
  input  logic rst_n,
  htw_in_if    in_mon,
  htw_out_if   out_mon,
  output int   errors,
  output int   awaited
);
  import htw_pkg::*;

  localparam logic [31:0] LAPS_MAX = (32'd1 << REV_W) - 32'd1;

  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [SLOT_W-1:0] slot;
    logic              last;
  } expiry_t;

  logic                armed    [NUM_TIMERS];
  logic [BUCKET_W-1:0] home     [NUM_TIMERS];
  logic [REV_W-1:0]    laps     [NUM_TIMERS];
  logic [TAG_W-1:0]    timer_id [NUM_TIMERS];
  logic [BUCKET_W-1:0] hand;
  logic [TIME_W-1:0]   tick_stamp;
  expiry_t             expiry_q [$];

  initial begin
    errors  = 0;
    awaited = 0;
  end

  // A negative distance counts as zero steps; laps saturate at the counter width.
  function automatic void file_timer(input logic [SLOT_W-1:0] idx,
                                     input logic [TIME_W-1:0] now,
                                     input logic [TIME_W-1:0] dur,
                                     input logic [TAG_W-1:0]  tag);
    logic [31:0] span;
    logic [31:0] steps;
    logic [31:0] turns;
    span  = now + dur - tick_stamp;
    steps = span[31] ? 32'd0 : span / RESOLUTION_MS;
    turns = steps / BUCKETS;
    if (turns > LAPS_MAX) begin
      turns = LAPS_MAX;
    end
    home[idx]     = BUCKET_W'((32'(hand) + steps) % BUCKETS);
    laps[idx]     = turns[REV_W-1:0];
    timer_id[idx] = tag;
    armed[idx]    = 1'b1;
  endfunction

  function automatic void advance_wheel();
    int fired;
    fired      = 0;
    tick_stamp = tick_stamp + RESOLUTION_MS;
    hand       = BUCKET_W'((32'(hand) + 1) % BUCKETS);
    for (int i = 0; i < NUM_TIMERS; i++) begin
      if (armed[i] && home[i] == hand) begin
        if (laps[i] == '0) begin
          armed[i] = 1'b0;
          expiry_q.push_back('{tag: timer_id[i], slot: SLOT_W'(i), last: 1'b0});
          fired++;
        end else begin
          laps[i] = laps[i] - 1'b1;
        end
      end
    end
    if (fired > 0) begin
      expiry_q[expiry_q.size() - 1].last = 1'b1;
    end
  endfunction

  always @(posedge clk) begin : watch
    expiry_t want;
    if (!rst_n) begin
      for (int i = 0; i < NUM_TIMERS; i++) begin
        armed[i] = 1'b0;
      end
      hand       = '0;
      tick_stamp = '0;
      expiry_q.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (expiry_q.size() == 0) begin
          $display("%0t: unexpected expiry beat: got tag %h slot %0d last %b", $time,
                   out_mon.expired_tag, out_mon.expired_slot, out_mon.last);
          errors++;
        end else begin
          want = expiry_q.pop_front();
          if (out_mon.expired_tag !== want.tag || out_mon.expired_slot !== want.slot ||
              out_mon.last !== want.last) begin
            $display("%0t: expiry mismatch: expected tag %h slot %0d last %b, got tag %h slot %0d last %b",
                     $time, want.tag, want.slot, want.last,
                     out_mon.expired_tag, out_mon.expired_slot, out_mon.last);
            errors++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        case (in_mon.action)
          ACT_SCHEDULE: begin
            if (in_mon.slot < NUM_TIMERS) begin
              file_timer(in_mon.slot, in_mon.now_ms, in_mon.duration_ms, in_mon.timer_tag);
            end
          end
          ACT_CANCEL: begin
            if (in_mon.slot < NUM_TIMERS) begin
              armed[in_mon.slot] = 1'b0;
            end
          end
          ACT_TICK: begin
            advance_wheel();
          end
          default: begin
          end
        endcase
      end
    end
    awaited = expiry_q.size();
  end

endmodule

[tb/tb_hashed_timing_wheel.sv]
// Testbench top for the hashed timing wheel: clock, reset, request and expiry
// stimulus with random idling, and the verdict. Depends on htw_pkg, htw_ifs,
// hashed_timing_wheel and htw_expiry_checker.
module tb_hashed_timing_wheel;
  import htw_pkg::*;

  localparam int CLK_HALF       = 6;
  localparam int RESET_CYCLES   = 9;
  localparam int RANDOM_ITEMS   = 270;
  localparam int SQUEEZE_CYCLES = 300;
  localparam int DRAIN_CYCLES   = 60;
  localparam int CYCLE_LIMIT    = 200000;

  // The one action code the block leaves unused; a beat carrying it must be
  // swallowed without any effect.
  localparam logic [ACTION_W-1:0] ACT_IDLE = 2'd3;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  htw_in_if  in_bus ();
  htw_out_if out_bus ();

  int errors;
  int awaited;

  // Stimulus keeps its own count of wheel time so that schedules can be aimed
  // a chosen number of steps ahead. It advances only when a tick beat is taken,
  // which is exactly when the block advances its own tick time.
  logic [TIME_W-1:0] tick_time = '0;

  // Set by the stimulus to ask the receiver for one long hold-off.
  bit squeeze_req = 1'b0;
  // While set, the sender offers beats back to back.
  bit send_calm   = 1'b0;

  hashed_timing_wheel DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  htw_expiry_checker u_expiry_chk (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_mon  (in_bus),
    .out_mon (out_bus),
    .errors  (errors),
    .awaited (awaited)
  );

  always #CLK_HALF clk = ~clk;

  // Offer one request beat. We enter and leave on a falling edge; valid stays
  // high across back-to-back beats so it never gets two updates in one step.
  task automatic send_beat(input logic [ACTION_W-1:0] act,
                           input logic [SLOT_W-1:0]   slot,
                           input logic [TIME_W-1:0]   now,
                           input logic [TIME_W-1:0]   dur,
                           input logic [TAG_W-1:0]    tag);
    int gap;
    gap = send_calm ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_bus.valid       <= 1'b1;
    in_bus.action      <= act;
    in_bus.slot        <= slot;
    in_bus.now_ms      <= now;
    in_bus.duration_ms <= dur;
    in_bus.timer_tag   <= tag;
    do @(posedge clk); while (!in_bus.ready);
    @(negedge clk);
    if (act == ACT_TICK) begin
      tick_time = tick_time + RESOLUTION_MS;
    end
  endtask

  // A tick carries random junk in every field it does not use.
  task automatic send_tick();
    send_beat(ACT_TICK, SLOT_W'($urandom), $urandom, $urandom, $urandom);
  endtask

  // Schedule a slot so that it lands a given number of wheel steps ahead of
  // the last tick, from a random current time and with a random sub-step offset.
  task automatic schedule_ahead(input logic [SLOT_W-1:0] slot, input int steps,
                                input logic [TAG_W-1:0] tag);
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] target;
    now    = $urandom;
    target = tick_time + 32'(steps * RESOLUTION_MS) + $urandom_range(0, RESOLUTION_MS - 1);
    send_beat(ACT_SCHEDULE, slot, now, target - now, tag);
  endtask

  // Request side: a short directed sequence, then a mostly well-formed random
  // stream of schedules and ticks with some cancels, junk schedules and unused
  // action codes mixed in.
  initial begin : stimulus
    int items;
    int mix;
    int steps;
    int group;
    in_bus.valid       = 1'b0;
    in_bus.action      = ACT_SCHEDULE;
    in_bus.slot        = '0;
    in_bus.now_ms      = '0;
    in_bus.duration_ms = '0;
    in_bus.timer_tag   = '0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Cancel of a slot that was never scheduled, and the unused action code
    // with every field at its top value: neither may do anything.
    send_beat(ACT_CANCEL, 4'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_beat(ACT_IDLE, 4'hF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // Empty tick: no expiry beats.
    send_tick();
    // Two expiries in one tick (lowest and highest slot), then a lone one.
    schedule_ahead(4'd0, 1, 32'h0000_0000);
    schedule_ahead(4'd15, 1, 32'hFFFF_FFFF);
    schedule_ahead(4'd7, 2, 32'hA5A5_5A5A);
    send_tick();
    send_tick();
    // Both time fields at their top value wrap to a negative distance, which
    // counts as zero steps; an exact zero distance goes the same way. Both
    // timers sit in the current bucket and wait out a whole turn.
    send_beat(ACT_SCHEDULE, 4'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h1357_9BDF);
    send_beat(ACT_SCHEDULE, 4'd4, tick_time, 32'd0, 32'h2468_ACE0);
    // Largest positive distance: a huge revolution count.
    send_beat(ACT_SCHEDULE, 4'd5, tick_time, 32'h7FFF_FFFF, 32'h8000_0001);
    // One full revolution plus two steps: the bucket is hit once without firing.
    schedule_ahead(4'd6, BUCKETS + 2, 32'h0F0F_F0F0);
    // Reschedule replaces the earlier entry; a cancel withdraws a pending timer.
    schedule_ahead(4'd8, 2, 32'h1111_1111);
    schedule_ahead(4'd8, 1, 32'h2222_2222);
    schedule_ahead(4'd9, 1, 32'h3333_3333);
    send_beat(ACT_CANCEL, 4'd9, 32'd0, 32'd0, 32'd0);
    schedule_ahead(4'd10, 3, 32'h4444_4444);
    // Current time of zero.
    send_beat(ACT_SCHEDULE, 4'd11, 32'd0, tick_time + 4 * RESOLUTION_MS, 32'h5555_5555);
    repeat (4) send_tick();

    // Arm the long receiver hold-off, then load every slot to fire within a
    // few steps so that expiries pile up behind the stalled output and the
    // block backs up into the request channel.
    squeeze_req = 1'b1;
    for (int s = 0; s < NUM_TIMERS; s++) begin
      schedule_ahead(SLOT_W'(s), $urandom_range(1, 3), $urandom);
    end
    items = NUM_TIMERS;

    while (items < RANDOM_ITEMS) begin
      if (items % 40 == 0) begin
        send_calm = ($urandom_range(0, 2) == 0);
      end
      mix = $urandom_range(0, 99);
      if (mix < 56) begin
        send_tick();
      end else if (mix < 78) begin
        // Near-term schedule; zero steps lands in the current bucket.
        schedule_ahead(SLOT_W'($urandom), $urandom_range(0, 12), $urandom);
      end else if (mix < 82) begin
        // Far schedule, sometimes past a full revolution.
        schedule_ahead(SLOT_W'($urandom), $urandom_range(13, 300), $urandom);
      end else if (mix < 87) begin
        // Junk schedule: both time fields fully random.
        send_beat(ACT_SCHEDULE, SLOT_W'($urandom), $urandom, $urandom, $urandom);
      end else if (mix < 93) begin
        send_beat(ACT_CANCEL, SLOT_W'($urandom), $urandom, $urandom, $urandom);
      end else if (mix < 98) begin
        // A few timers on the same step, for ticks with several expiries.
        steps = $urandom_range(1, 4);
        group = $urandom_range(2, 4);
        repeat (group) schedule_ahead(SLOT_W'($urandom), steps, $urandom);
        items += group - 1;
      end else begin
        send_beat(ACT_IDLE, SLOT_W'($urandom), $urandom, $urandom, $urandom);
      end
      items++;
    end
    in_bus.valid <= 1'b0;

    // Wait for every predicted expiry, then a little longer so that a late
    // extra beat would still be caught.
    while (awaited != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0) begin
      $display("PASS hashed_timing_wheel");
    end else begin
      $display("FAIL hashed_timing_wheel");
    end
    $finish;
  end

  // Expiry side: a random number of idle cycles before each beat, with calm
  // stretches of back-to-back acceptance, and one long hold-off on request.
  initial begin : receiver
    int gap;
    int beats;
    bit recv_calm;
    out_bus.ready = 1'b0;
    beats     = 0;
    recv_calm = 1'b0;
    @(negedge clk);
    while (!rst_n) @(negedge clk);
    forever begin
      if (squeeze_req) begin
        squeeze_req = 1'b0;
        out_bus.ready <= 1'b0;
        repeat (SQUEEZE_CYCLES) @(negedge clk);
      end
      if (beats % 32 == 0) begin
        recv_calm = ($urandom_range(0, 2) == 0);
      end
      gap = recv_calm ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
        out_bus.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk); while (!out_bus.valid);
      beats++;
      @(negedge clk);
    end
  end

  // Watchdog on the total run length.
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAIL hashed_timing_wheel");
    $finish;
  end

endmodule
